// ===== hdl/dte_pkg.sv =====
// Package for the disparity to Euclidean range block.
// Holds the configuration record, register indexes, mode bit positions and constants.
// No dependencies.
package dte_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int CFG_DATA_W      = 48;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_DECIM     = 3'd1,
        REG_DRV_OFF   = 3'd2,
        REG_DISP_OFF  = 3'd3,
        REG_BASELINE  = 3'd4,
        REG_FOCAL     = 3'd5,
        REG_CENTER    = 3'd6,
        REG_MAX_DEPTH = 3'd7
    } t_cfg_idx;

    // mode bit positions
    localparam int MODE_WIDE  = 0;
    localparam int MODE_DIV10 = 1;
    localparam int MODE_IGNZ  = 2;
    localparam int MODE_Q16   = 3;

    typedef struct packed {
        logic [3:0]  mode_bits;
        logic [3:0]  decimation;
        logic [15:0] driver_offset;
        logic [15:0] disparity_offset;
        logic [15:0] baseline;
        logic [47:0] focal_xy;
        logic [47:0] center_xy;
        logic [31:0] max_depth;
    } t_cfg;

    localparam logic [3:0]  RST_DECIM     = 4'd1;
    localparam logic [15:0] RST_BASELINE  = 16'd4915;
    localparam logic [31:0] RST_MAX_DEPTH = 32'hFFFF_FFFF;

    // floor(d / 10) = (d * DIV10_MUL) >> DIV10_SHIFT, exact for d below 2**21
    localparam logic [19:0] DIV10_MUL   = 20'd838861;
    localparam int          DIV10_SHIFT = 23;

    localparam logic [9:0]  MM_PER_M    = 10'd1000;
    localparam logic [15:0] MM_MAX      = 16'hFFFF;

endpackage

// ===== hdl/dte_udiv_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Expects the starting remainder below the divisor. Does not use dte_pkg.
module dte_udiv_pipe #(
    parameter int Q_W = 32,
    parameter int D_W = 24,
    parameter int S_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [D_W-1:0] i_rem,
    input  logic [Q_W-1:0] i_num,
    input  logic [D_W-1:0] i_div,
    input  logic [S_W-1:0] i_side,
    output logic           o_valid,
    output logic [Q_W-1:0] o_quo,
    output logic [S_W-1:0] o_side
);

    logic           r_v    [Q_W];
    logic [D_W-1:0] r_rem  [Q_W];
    logic [Q_W-1:0] r_num  [Q_W];
    logic [D_W-1:0] r_div  [Q_W];
    logic [S_W-1:0] r_side [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic           c_v;
        logic [D_W-1:0] c_rem;
        logic [Q_W-1:0] c_num;
        logic [D_W-1:0] c_div;
        logic [S_W-1:0] c_side;
        logic [D_W:0]   c_t;
        logic           c_ge;
        logic [D_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = i_rem;
            assign c_num  = i_num;
            assign c_div  = i_div;
            assign c_side = i_side;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_num  = r_num[k-1];
            assign c_div  = r_div[k-1];
            assign c_side = r_side[k-1];
        end

        assign c_t   = {c_rem, c_num[Q_W-1]};
        assign c_ge  = c_t >= {1'b0, c_div};
        assign n_rem = c_ge ? D_W'(c_t - {1'b0, c_div}) : c_t[D_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= {c_num[Q_W-2:0], c_ge};
                r_div[k]  <= c_div;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo   = r_num[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

// ===== hdl/dte_isqrt_pipe.sv =====
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Standalone; used by the top level.
module dte_isqrt_pipe #(
    parameter int S_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [63:0]    i_val,
    input  logic [S_W-1:0] i_side,
    output logic           o_valid,
    output logic [31:0]    o_root,
    output logic [S_W-1:0] o_side
);

    localparam int N_ST = 32;

    logic           r_v    [N_ST];
    logic [33:0]    r_rem  [N_ST];
    logic [31:0]    r_root [N_ST];
    logic [63:0]    r_rest [N_ST];
    logic [S_W-1:0] r_side [N_ST];

    for (genvar k = 0; k < N_ST; k++) begin : g_stage
        logic           c_v;
        logic [33:0]    c_rem;
        logic [31:0]    c_root;
        logic [63:0]    c_rest;
        logic [S_W-1:0] c_side;
        logic [35:0]    c_t;
        logic [35:0]    c_trial;
        logic           c_ge;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_rest = i_val;
            assign c_side = i_side;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_root = r_root[k-1];
            assign c_rest = r_rest[k-1];
            assign c_side = r_side[k-1];
        end

        assign c_t     = {c_rem, c_rest[63:62]};
        assign c_trial = {2'b00, c_root, 2'b01};
        assign c_ge    = c_t >= c_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= c_ge ? 34'(c_t - c_trial) : c_t[33:0];
                r_root[k] <= {c_root[30:0], c_ge};
                r_rest[k] <= {c_rest[61:0], 2'b00};
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_v[N_ST-1];
    assign o_root  = r_root[N_ST-1];
    assign o_side  = r_side[N_ST-1];

endmodule

// ===== hdl/disparity_to_euclidean_distance_top.sv =====
// Throughput: one pixel per cycle while the output is not stalled.
// The pipeline is the 40-stage depth divider, the two 32-stage coordinate dividers in
// parallel and the 32-stage square root, plus nine stages of scaling, products and output.
// A stall on the output freezes the whole pipeline. Synchronous active-low reset clears
// all valid bits and loads the register defaults.
// Top level: configuration registers and pipeline stages; uses dte_pkg, dte_udiv_pipe,
// dte_isqrt_pipe.
module disparity_to_euclidean_distance_top #(
    parameter int COORD_WIDTH = dte_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dte_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dte_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [15:0]                    i_disparity_raw,
    input  logic [COORD_WIDTH-1:0]         i_column,
    input  logic [COORD_WIDTH-1:0]         i_row,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [31:0]                    o_distance_value,
    output logic                           o_invalid
);

    localparam int CW   = COORD_WIDTH;
    localparam int XW   = (CW + 12 > 24) ? CW + 12 : 24;
    localparam int NX_W = XW + 32;
    localparam int DS_W = 2 * CW + 1;

    dte_pkg::t_cfg r_cfg;
    logic          en;
    logic          r_out_valid;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_bits        <= '0;
            r_cfg.decimation       <= dte_pkg::RST_DECIM;
            r_cfg.driver_offset    <= '0;
            r_cfg.disparity_offset <= '0;
            r_cfg.baseline         <= dte_pkg::RST_BASELINE;
            r_cfg.focal_xy         <= '0;
            r_cfg.center_xy        <= '0;
            r_cfg.max_depth        <= dte_pkg::RST_MAX_DEPTH;
        end else if (i_cfg_we) begin
            case (dte_pkg::t_cfg_idx'(i_cfg_idx))
                dte_pkg::REG_MODE:      r_cfg.mode_bits        <= i_cfg_data[3:0];
                dte_pkg::REG_DECIM:     r_cfg.decimation       <= i_cfg_data[3:0];
                dte_pkg::REG_DRV_OFF:   r_cfg.driver_offset    <= i_cfg_data[15:0];
                dte_pkg::REG_DISP_OFF:  r_cfg.disparity_offset <= i_cfg_data[15:0];
                dte_pkg::REG_BASELINE:  r_cfg.baseline         <= i_cfg_data[15:0];
                dte_pkg::REG_FOCAL:     r_cfg.focal_xy         <= i_cfg_data;
                dte_pkg::REG_CENTER:    r_cfg.center_xy        <= i_cfg_data;
                dte_pkg::REG_MAX_DEPTH: r_cfg.max_depth        <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic [23:0] fx, fy, cx, cy;
    assign fx = r_cfg.focal_xy[23:0];
    assign fy = r_cfg.focal_xy[47:24];
    assign cx = r_cfg.center_xy[23:0];
    assign cy = r_cfg.center_xy[47:24];

    // stage 1: disparity to Q.8
    logic          r1_v;
    logic [20:0]   r1_d;
    logic [CW-1:0] r1_u, r1_v_row;

    // stage 2: divide-by-ten product
    logic          r2_v;
    logic [20:0]   r2_d;
    logic [40:0]   r2_prod;
    logic [CW-1:0] r2_u, r2_row;

    // stage 3: offsets, denominator, numerator
    logic          r3_v;
    logic [21:0]   r3_den;
    logic [39:0]   r3_num;
    logic          r3_bad;
    logic [CW-1:0] r3_u, r3_row;

    logic [20:0]   n_dd, n_d2;
    logic [22:0]   n_den;
    logic          n_bad3;

    always_comb begin
        n_dd  = r_cfg.mode_bits[dte_pkg::MODE_DIV10]
              ? 21'(r2_prod[40:dte_pkg::DIV10_SHIFT]) : r2_d;
        n_d2  = (n_dd < {1'b0, r_cfg.driver_offset, 4'b0})
              ? '0 : 21'(n_dd - {1'b0, r_cfg.driver_offset, 4'b0});
        n_den = {2'b00, n_d2}
              + {{3{r_cfg.disparity_offset[15]}}, r_cfg.disparity_offset, 4'b0};
        n_bad3 = n_den[22] || (n_den == '0)
              || (r_cfg.mode_bits[dte_pkg::MODE_IGNZ] && (n_d2 == '0))
              || (fx == '0) || (fy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d     <= r_cfg.mode_bits[dte_pkg::MODE_WIDE]
                      ? {i_disparity_raw, 5'b0} : {5'b0, i_disparity_raw[7:0], 8'b0};
            r1_u     <= i_column;
            r1_v_row <= i_row;
            r2_d     <= r1_d;
            r2_prod  <= r1_d * dte_pkg::DIV10_MUL;
            r2_u     <= r1_u;
            r2_row   <= r1_v_row;
            r3_den   <= n_den[21:0];
            r3_num   <= fx * r_cfg.baseline;
            r3_bad   <= n_bad3;
            r3_u     <= r2_u;
            r3_row   <= r2_row;
        end
    end

    // depth divider
    logic            dq_v;
    logic [39:0]     dq_quo;
    logic [DS_W-1:0] dq_side;

    dte_udiv_pipe #(.Q_W(40), .D_W(22), .S_W(DS_W)) u_depth_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_rem   ('0),
        .i_num   (r3_num),
        .i_div   (r3_den),
        .i_side  ({r3_bad, r3_u, r3_row}),
        .o_valid (dq_v),
        .o_quo   (dq_quo),
        .o_side  (dq_side)
    );

    // stage 4: depth check and pixel offsets
    logic          r4_v;
    logic [31:0]   r4_depth;
    logic          r4_bad;
    logic [XW-1:0] r4_axm, r4_aym;

    logic [CW-1:0] d_u, d_row;
    logic          d_bad;
    logic [XW:0]   n_dx, n_dy;

    assign {d_bad, d_u, d_row} = dq_side;

    always_comb begin
        n_dx = (XW+1)'({(CW+4)'(d_u) * (CW+4)'(r_cfg.decimation), 8'b0}) - (XW+1)'(cx);
        n_dy = (XW+1)'({(CW+4)'(d_row) * (CW+4)'(r_cfg.decimation), 8'b0}) - (XW+1)'(cy);
    end

    // stage 5: products for projection
    logic            r5_v;
    logic [NX_W-1:0] r5_nx, r5_ny;
    logic [31:0]     r5_depth;
    logic            r5_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r4_v <= dq_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_depth <= dq_quo[31:0];
            r4_bad   <= d_bad || (dq_quo > {8'b0, r_cfg.max_depth});
            r4_axm   <= n_dx[XW] ? XW'(-n_dx) : n_dx[XW-1:0];
            r4_aym   <= n_dy[XW] ? XW'(-n_dy) : n_dy[XW-1:0];
            r5_nx    <= r4_axm * r4_depth;
            r5_ny    <= r4_aym * r4_depth;
            r5_depth <= r4_depth;
            r5_bad   <= r4_bad;
        end
    end

    // coordinate dividers: quotient at or above 2**32 saturates
    logic        ovf_x, ovf_y;
    assign ovf_x = r5_nx[NX_W-1:32] >= XW'(fx);
    assign ovf_y = r5_ny[NX_W-1:32] >= XW'(fy);

    logic        qx_v, qy_v;
    logic [31:0] qx, qy;
    logic [33:0] qx_side;
    logic        qy_bad;

    dte_udiv_pipe #(.Q_W(32), .D_W(24), .S_W(34)) u_x_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_rem   (ovf_x ? 24'd0 : r5_nx[55:32]),
        .i_num   (r5_nx[31:0]),
        .i_div   (fx),
        .i_side  ({r5_depth, ovf_x, ovf_y}),
        .o_valid (qx_v),
        .o_quo   (qx),
        .o_side  (qx_side)
    );

    dte_udiv_pipe #(.Q_W(32), .D_W(24), .S_W(1)) u_y_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_rem   (ovf_y ? 24'd0 : r5_ny[55:32]),
        .i_num   (r5_ny[31:0]),
        .i_div   (fy),
        .i_side  (r5_bad),
        .o_valid (qy_v),
        .o_quo   (qy),
        .o_side  (qy_bad)
    );

    // stage 7: squares; stage 8: sum
    logic        r7_v, r7_sat, r7_bad;
    logic [63:0] r7_sx, r7_sy, r7_sz;
    logic        r8_v, r8_sat, r8_bad;
    logic [63:0] r8_sum;
    logic [65:0] n_sum;

    assign n_sum = {2'b00, r7_sx} + {2'b00, r7_sy} + {2'b00, r7_sz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (en) begin
            r7_v <= qx_v && qy_v;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sx  <= qx * qx;
            r7_sy  <= qy * qy;
            r7_sz  <= qx_side[33:2] * qx_side[33:2];
            r7_sat <= qx_side[1] || qx_side[0];
            r7_bad <= qy_bad;
            r8_sum <= n_sum[63:0];
            r8_sat <= r7_sat || (n_sum[65:64] != 2'b00);
            r8_bad <= r7_bad;
        end
    end

    // square root
    logic        sq_v;
    logic [31:0] sq_root;
    logic [1:0]  sq_side;

    dte_isqrt_pipe #(.S_W(2)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_val   (r8_sum),
        .i_side  ({r8_sat, r8_bad}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage 9: millimetre product; stage 10: output register
    logic        r9_v, r9_bad;
    logic [31:0] r9_root;
    logic [41:0] r9_mm;
    logic [31:0] n_root;
    logic [31:0] n_out;

    assign n_root = sq_side[1] ? '1 : sq_root;

    always_comb begin
        if (r9_bad) begin
            n_out = '0;
        end else if (r_cfg.mode_bits[dte_pkg::MODE_Q16]) begin
            n_out = r9_root;
        end else if (r9_mm[41:32] != '0) begin
            n_out = {16'b0, dte_pkg::MM_MAX};
        end else begin
            n_out = {16'b0, r9_mm[31:16]};
        end
    end

    logic [31:0] r_out_val;
    logic        r_out_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r9_v        <= sq_v;
            r_out_valid <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_root   <= n_root;
            r9_mm     <= n_root * dte_pkg::MM_PER_M;
            r9_bad    <= sq_side[0];
            r_out_val <= n_out;
            r_out_inv <= r9_bad;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_distance_value = r_out_val;
    assign o_invalid        = r_out_inv;

endmodule

// ===== tb/disparity_to_euclidean_distance_top_tb.sv =====
// Self-checking testbench for disparity_to_euclidean_distance_top: per-pixel range prediction,
// directed and random pixels under several register settings, random handshake stalls.
// Depends on dte_pkg and the RTL top level.
`timescale 1ns / 100ps

module disparity_to_euclidean_distance_top_tb;

    localparam int CW         = dte_pkg::COORD_WIDTH_DEF;
    localparam int DRAIN_CYC  = 130;

    typedef struct {
        logic [31:0] range_val;
        logic        inv;
    } t_range;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [dte_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [dte_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_valid;
    logic                           o_ready;
    logic [15:0]                    i_disparity_raw;
    logic [CW-1:0]                  i_column;
    logic [CW-1:0]                  i_row;
    logic                           o_valid;
    logic                           i_ready;
    logic [31:0]                    o_distance_value;
    logic                           o_invalid;

    dte_pkg::t_cfg cfg_shadow;
    t_range        range_q[$];
    int            err_cnt;
    bit            tx_gaps;
    bit            rx_stalls;
    bit            hold_rx;

    disparity_to_euclidean_distance_top #(.COORD_WIDTH(CW)) u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("disparity_to_euclidean_distance_top: mismatch");
        $finish;
    end

    function automatic logic [63:0] isqrt_u64(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] axis_mag(logic [CW-1:0] pix, logic [23:0] c, logic [23:0] f,
                                             logic [63:0] depth);
        longint dx;
        longint q;
        dx = longint'(pix) * longint'(cfg_shadow.decimation) * 256 - longint'(c);
        q  = dx * longint'(depth) / longint'(f);
        return (q < 0) ? 64'(-q) : 64'(q);
    endfunction

    function automatic t_range predict_range(logic [15:0] raw, logic [CW-1:0] col,
                                             logic [CW-1:0] row);
        t_range      r;
        logic [63:0] d, drv, depth, ax, ay, res;
        logic [65:0] sumsq;
        logic [23:0] fx, fy, cx, cy;
        longint      den;
        bit          bad;
        fx    = cfg_shadow.focal_xy[23:0];
        fy    = cfg_shadow.focal_xy[47:24];
        cx    = cfg_shadow.center_xy[23:0];
        cy    = cfg_shadow.center_xy[47:24];
        depth = '0;
        res   = '0;
        d = cfg_shadow.mode_bits[dte_pkg::MODE_WIDE] ? (64'(raw) << 5) : (64'(raw[7:0]) << 8);
        if (cfg_shadow.mode_bits[dte_pkg::MODE_DIV10]) d = d / 10;
        drv = 64'(cfg_shadow.driver_offset) << 4;
        d   = (d < drv) ? 64'd0 : d - drv;
        den = longint'(d) + longint'($signed(cfg_shadow.disparity_offset)) * 16;
        bad = den <= 0 || (cfg_shadow.mode_bits[dte_pkg::MODE_IGNZ] && d == 0)
              || fx == 0 || fy == 0;
        if (!bad) begin
            depth = (64'(fx) * 64'(cfg_shadow.baseline)) / 64'(den);
            if (depth > 64'(cfg_shadow.max_depth)) bad = 1'b1;
        end
        if (!bad) begin
            ax = axis_mag(col, cx, fx, depth);
            ay = axis_mag(row, cy, fy, depth);
            if (ax > 64'hFFFF_FFFF || ay > 64'hFFFF_FFFF) begin
                res = 64'hFFFF_FFFF;
            end else begin
                sumsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(depth) * 66'(depth);
                res   = (sumsq[65:64] != 0) ? 64'hFFFF_FFFF : isqrt_u64(sumsq[63:0]);
                if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
            end
            if (!cfg_shadow.mode_bits[dte_pkg::MODE_Q16]) begin
                res = (res * 1000) >> 16;
                if (res > 64'd65535) res = 64'd65535;
            end
        end
        r.range_val = bad ? 32'd0 : res[31:0];
        r.inv       = bad;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_range e;
        if (i_rst_n && o_valid && i_ready) begin
            if (range_q.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual range=%h inv=%b",
                         $time, o_distance_value, o_invalid);
                err_cnt++;
            end else begin
                e = range_q.pop_front();
                if (o_distance_value !== e.range_val) begin
                    $display("%0t: distance expected %h actual %h", $time, e.range_val,
                             o_distance_value);
                    err_cnt++;
                end
                if (o_invalid !== e.inv) begin
                    $display("%0t: invalid expected %b actual %b", $time, e.inv, o_invalid);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial begin
        int n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_ready = 1'b0;
                for (n = 0; n < 400; n++) @(negedge i_clk);
                hold_rx = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_pixel(logic [15:0] raw, logic [CW-1:0] col, logic [CW-1:0] row);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_disparity_raw = raw;
        i_column        = col;
        i_row           = row;
        do @(posedge i_clk); while (!o_ready);
        range_q.push_back(predict_range(raw, col, row));
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid = 1'b0;
        while (range_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(dte_pkg::t_cfg_idx idx, logic [dte_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            dte_pkg::REG_MODE:      cfg_shadow.mode_bits        = data[3:0];
            dte_pkg::REG_DECIM:     cfg_shadow.decimation       = data[3:0];
            dte_pkg::REG_DRV_OFF:   cfg_shadow.driver_offset    = data[15:0];
            dte_pkg::REG_DISP_OFF:  cfg_shadow.disparity_offset = data[15:0];
            dte_pkg::REG_BASELINE:  cfg_shadow.baseline         = data[15:0];
            dte_pkg::REG_FOCAL:     cfg_shadow.focal_xy         = data[47:0];
            dte_pkg::REG_CENTER:    cfg_shadow.center_xy        = data[47:0];
            dte_pkg::REG_MAX_DEPTH: cfg_shadow.max_depth        = data[31:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [3:0] mode, logic [3:0] decim, logic [15:0] drv,
                             logic [15:0] doff, logic [15:0] base, logic [47:0] focal,
                             logic [47:0] centre, logic [31:0] maxd);
        write_reg(dte_pkg::REG_MODE, 48'(mode));
        write_reg(dte_pkg::REG_DECIM, 48'(decim));
        write_reg(dte_pkg::REG_DRV_OFF, 48'(drv));
        write_reg(dte_pkg::REG_DISP_OFF, 48'(doff));
        write_reg(dte_pkg::REG_BASELINE, 48'(base));
        write_reg(dte_pkg::REG_FOCAL, focal);
        write_reg(dte_pkg::REG_CENTER, centre);
        write_reg(dte_pkg::REG_MAX_DEPTH, 48'(maxd));
    endtask

    task automatic write_random_cfg;
        logic [3:0]  decim;
        logic [15:0] drv, doff;
        logic [23:0] fx, fy;
        logic [31:0] maxd;
        decim = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
        drv   = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(0, 16'h0FFF));
        if ($urandom_range(0, 9) == 0) drv = 16'($urandom);
        doff  = 16'($signed($urandom_range(0, 2047)) - 1024);
        if ($urandom_range(0, 9) == 0) doff = 16'($urandom);
        fx    = ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(256, 384000));
        fy    = ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(256, 384000));
        maxd  = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
        write_all(4'($urandom), decim, drv, doff, 16'($urandom), {fy, fx},
                  {24'($urandom_range(0, 1048320)), 24'($urandom_range(0, 1048320))}, maxd);
    endtask

    task automatic send_random(int count);
        logic [15:0] raw;
        repeat (count) begin
            case ($urandom_range(0, 7))
                0:       raw = 16'd0;
                1, 2:    raw = 16'($urandom_range(0, 255));
                default: raw = 16'($urandom);
            endcase
            send_pixel(raw, CW'($urandom), CW'($urandom));
        end
    endtask

    // reset values: zero focal lengths make every pixel invalid
    task automatic test_reset_defaults;
        send_pixel(16'd40, 12'd0, 12'd0);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
        drain();
    endtask

    task automatic test_directed;
        // plain 8-bit millimetres, zero disparity and field extremes
        write_all(4'd0, 4'd1, 16'd0, 16'd0, 16'd4915, {24'd179200, 24'd179200},
                  {24'd163840, 24'd122880}, 32'hFFFF_FFFF);
        send_pixel(16'd0, 12'd0, 12'd0);
        send_pixel(16'h00FF, 12'hFFF, 12'hFFF);
        send_pixel(16'hFF01, 12'd640, 12'd480);
        send_pixel(16'd1, 12'd0, 12'hFFF);
        drain();
        // wide, divide by ten, ignore zero, driver offset floor, max decimation
        write_all(4'b0111, 4'd15, 16'd100, 16'd0, 16'hFFFF, {24'hFFFFFF, 24'hFFFFFF},
                  48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
        send_pixel(16'd10, 12'd0, 12'd0);
        send_pixel(16'h8000, 12'd1, 12'd2);
        drain();
        // Q16.16 with negative and positive disparity offsets, decimation zero
        write_all(4'b1001, 4'd0, 16'd0, 16'h8000, 16'hFFFF, {24'hFFFFFF, 24'hFFFFFF},
                  48'd0, 32'hFFFF_FFFF);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
        drain();
        write_reg(dte_pkg::REG_DISP_OFF, 48'h7FFF);
        send_pixel(16'd0, 12'hFFF, 12'hFFF);
        send_pixel(16'd1, 12'd0, 12'd0);
        drain();
        write_reg(dte_pkg::REG_DECIM, 48'd9);
        send_pixel(16'd1, 12'hFFF, 12'hFFF);
        drain();
        // depth limit and zero baseline
        write_reg(dte_pkg::REG_MAX_DEPTH, 48'd0);
        send_pixel(16'd200, 12'd10, 12'd10);
        drain();
        write_reg(dte_pkg::REG_BASELINE, 48'd0);
        send_pixel(16'd200, 12'd10, 12'd10);
        drain();
        write_reg(dte_pkg::REG_MODE, 48'b1000);
        write_reg(dte_pkg::REG_MAX_DEPTH, 48'hFFFF_FFFF);
        send_pixel(16'd200, 12'd10, 12'd10);
        drain();
    endtask

    task automatic test_random_phases;
        int ph;
        for (ph = 0; ph < 6; ph++) begin
            tx_gaps   = (ph % 3) != 2;
            rx_stalls = (ph % 2) == 0;
            write_random_cfg();
            send_random(250);
            drain();
        end
    endtask

    task automatic test_backpressure;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
        write_random_cfg();
        hold_rx = 1'b1;
        send_random(200);
        drain();
    endtask

    task automatic test_steady_stream;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        write_random_cfg();
        send_random(50);
        drain();
    endtask

    initial begin
        err_cnt         = 0;
        tx_gaps         = 1'b1;
        rx_stalls       = 1'b1;
        hold_rx         = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = dte_pkg::REG_MODE;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_disparity_raw = '0;
        i_column        = '0;
        i_row           = '0;
        cfg_shadow      = '0;
        cfg_shadow.decimation = dte_pkg::RST_DECIM;
        cfg_shadow.baseline   = dte_pkg::RST_BASELINE;
        cfg_shadow.max_depth  = dte_pkg::RST_MAX_DEPTH;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed();
        test_random_phases();
        test_backpressure();
        test_steady_stream();

        if (err_cnt == 0) begin
            $display("disparity_to_euclidean_distance_top: match");
        end else begin
            $display("disparity_to_euclidean_distance_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dte_pkg.sv
hdl/dte_udiv_pipe.sv
hdl/dte_isqrt_pipe.sv
hdl/disparity_to_euclidean_distance_top.sv
tb/disparity_to_euclidean_distance_top_tb.sv
